>>> rtl/mktd_pkg.sv
// Shared types, constants and register map for the morse key timing decoder.
// No dependencies; imported by every module of the block.
package mktd_pkg;

	localparam int unsigned MAX_SYMBOLS_D = 8;
	localparam int unsigned REG_W         = 16;
	localparam int unsigned TICK_W        = 32;
	localparam int unsigned PATTERN_W     = 8;
	localparam int unsigned COUNT_W       = 4;
	localparam int unsigned CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DASH_MIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHAR_GAP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP = 2'd3;

	localparam logic [REG_W-1:0] DEBOUNCE_RST = 16'd10;
	localparam logic [REG_W-1:0] DASH_MIN_RST = 16'd180;
	localparam logic [REG_W-1:0] CHAR_GAP_RST = 16'd180;
	localparam logic [REG_W-1:0] WORD_GAP_RST = 16'd420;

	localparam logic EV_CHAR = 1'b0;
	localparam logic EV_WORD = 1'b1;

	typedef struct packed {
		logic [REG_W-1:0] debounce_ms;
		logic [REG_W-1:0] dash_min_ms;
		logic [REG_W-1:0] char_gap_ms;
		logic [REG_W-1:0] word_gap_ms;
	} mktd_cfg_t;

	typedef struct packed {
		logic                 valid;
		logic                 event_kind;
		logic [PATTERN_W-1:0] symbol_pattern;
		logic [COUNT_W-1:0]   symbol_count;
	} mktd_result_t;

endpackage

>>> rtl/mktd_cfg_regs.sv
// Configuration register file of the morse key timing decoder.
// Depends on mktd_pkg for the register map and reset values.
module mktd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mktd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mktd_pkg::REG_W-1:0]        cfg_wdata,
	output mktd_pkg::mktd_cfg_t               cfg
);
	import mktd_pkg::*;

	mktd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= DEBOUNCE_RST;
			cfg_q.dash_min_ms <= DASH_MIN_RST;
			cfg_q.char_gap_ms <= CHAR_GAP_RST;
			cfg_q.word_gap_ms <= WORD_GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ms <= cfg_wdata;
				REG_DASH_MIN: cfg_q.dash_min_ms <= cfg_wdata;
				REG_CHAR_GAP: cfg_q.char_gap_ms <= cfg_wdata;
				REG_WORD_GAP: cfg_q.word_gap_ms <= cfg_wdata;
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/mktd_core.sv
// Tick state, symbol buffer and per-tick decision logic of the decoder.
// Depends on mktd_pkg; driven by the top level once per transferred tick.
module mktd_core #(
	parameter int unsigned MAX_SYMBOLS_P = mktd_pkg::MAX_SYMBOLS_D
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   key,
	input  mktd_pkg::mktd_cfg_t    cfg,
	output mktd_pkg::mktd_result_t res
);
	import mktd_pkg::*;

	localparam int unsigned WP_W   = $clog2(MAX_SYMBOLS_P + 1);
	localparam int unsigned CNT_W  = $clog2(MAX_SYMBOLS_P + 1);
	localparam int unsigned PAT_N  = (MAX_SYMBOLS_P < PATTERN_W) ? MAX_SYMBOLS_P : PATTERN_W;

	logic [TICK_W-1:0]        tick_q;
	logic [TICK_W-1:0]        deb_stamp_q;
	logic [TICK_W-1:0]        press_start_q;
	logic                     press_active_q;
	logic [TICK_W-1:0]        sym_stamp_q;
	logic                     sym_valid_q;
	logic [TICK_W-1:0]        char_stamp_q;
	logic                     char_valid_q;
	logic [MAX_SYMBOLS_P-1:0] dash_q;
	logic [MAX_SYMBOLS_P-1:0] filled_q;
	logic [WP_W-1:0]          wp_q;

	logic [TICK_W-1:0] deb_diff, press_len, sym_gap, char_gap;
	logic              sample_ok, is_dash, word_due, char_due, buf_full;
	logic              do_press, do_release, do_word, do_char, do_idle;
	logic [CNT_W-1:0]  fill_cnt;
	logic [PATTERN_W-1:0] pattern;

	assign deb_diff  = tick_q - deb_stamp_q;
	assign press_len = tick_q - press_start_q;
	assign sym_gap   = tick_q - sym_stamp_q;
	assign char_gap  = tick_q - char_stamp_q;

	assign sample_ok = deb_diff >= TICK_W'(cfg.debounce_ms);
	assign is_dash   = press_len >= TICK_W'(cfg.dash_min_ms);
	assign word_due  = char_valid_q && (char_gap >= TICK_W'(cfg.word_gap_ms));
	assign char_due  = sym_valid_q && (sym_gap >= TICK_W'(cfg.char_gap_ms));
	assign buf_full  = wp_q >= WP_W'(MAX_SYMBOLS_P);

	assign do_press   = step && sample_ok && key && !press_active_q;
	assign do_release = step && sample_ok && !key && press_active_q;
	assign do_word    = step && sample_ok && !key && !press_active_q && word_due;
	assign do_char    = step && sample_ok && !key && !press_active_q && !word_due && char_due;
	assign do_idle    = step && sample_ok && !key && !press_active_q && !word_due && !char_due;

	always_comb begin
		fill_cnt = '0;
		for (int i = 0; i < MAX_SYMBOLS_P; i++) begin
			fill_cnt = fill_cnt + CNT_W'(filled_q[i]);
		end
	end

	generate
		for (genvar g = 0; g < PATTERN_W; g++) begin : g_pat
			if (g < PAT_N) begin : g_on
				assign pattern[g] = filled_q[g] & dash_q[g];
			end else begin : g_off
				assign pattern[g] = 1'b0;
			end
		end
	endgenerate

	always_comb begin
		res.valid          = do_word || do_char;
		res.event_kind     = do_word ? EV_WORD : EV_CHAR;
		res.symbol_pattern = do_char ? pattern : '0;
		res.symbol_count   = '0;
		if (do_char) begin
			if (32'(fill_cnt) > 32'd15) begin
				res.symbol_count = '1;
			end else begin
				res.symbol_count = COUNT_W'(fill_cnt);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q         <= '0;
			deb_stamp_q    <= '0;
			press_start_q  <= '0;
			press_active_q <= 1'b0;
			sym_stamp_q    <= '0;
			sym_valid_q    <= 1'b0;
			char_stamp_q   <= '0;
			char_valid_q   <= 1'b0;
			dash_q         <= '0;
			filled_q       <= '0;
			wp_q           <= '0;
		end else begin
			if (step) begin
				tick_q <= tick_q + 1'b1;
			end
			if (do_press) begin
				press_active_q <= 1'b1;
				press_start_q  <= tick_q;
			end
			if (do_release) begin
				if (buf_full) begin
					wp_q <= '0;
				end else begin
					for (int i = 0; i < MAX_SYMBOLS_P; i++) begin
						if (wp_q == WP_W'(i)) begin
							dash_q[i]   <= is_dash;
							filled_q[i] <= 1'b1;
						end
					end
					wp_q <= wp_q + 1'b1;
				end
				press_active_q <= 1'b0;
				sym_stamp_q    <= tick_q;
				sym_valid_q    <= 1'b1;
				char_valid_q   <= 1'b0;
			end
			if (do_word) begin
				char_valid_q <= 1'b0;
			end
			if (do_char) begin
				dash_q       <= '0;
				filled_q     <= '0;
				wp_q         <= '0;
				sym_valid_q  <= 1'b0;
				char_stamp_q <= tick_q;
				char_valid_q <= 1'b1;
			end
			if (do_idle) begin
				deb_stamp_q <= tick_q;
			end
		end
	end

	a_tick_adv: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> tick_q == $past(tick_q) + 1'b1)
		else $error("tick counter did not advance on a step");

	a_res_low: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> step && !key && !press_active_q)
		else $error("event raised outside an idle low sample");

	a_word_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.event_kind == EV_WORD |-> res.symbol_count == '0 &&
		res.symbol_pattern == '0)
		else $error("word space carries symbol data");

	a_char_clears: assert property (@(posedge clk) disable iff (!arst_n)
		do_char |=> filled_q == '0 && wp_q == '0 && char_valid_q)
		else $error("buffer not cleared after character");

endmodule

>>> rtl/morse_key_timing_decoder_unit.sv
// Top level of the morse key timing decoder: tick input register, output register.
// Depends on mktd_pkg, mktd_cfg_regs and mktd_core.
//
//   channel | direction | handshake          | payload
//   in      | sink      | in_valid/in_stall  | key_level
//   out     | source    | out_valid/out_stall| event_kind, symbol_pattern, symbol_count
//   cfg     | sink      | cfg_we             | cfg_index, cfg_wdata
//
// One tick per cycle sustained while the output register is not held; a tick waits in
// the input register until it advances, and its result (if any) is then registered.
// Reset clears all timing state, empties the symbol buffer, loads register defaults.
// A held output stalls the input only when the input register is also full.
module morse_key_timing_decoder_unit #(
	parameter int unsigned MAX_SYMBOLS_P = mktd_pkg::MAX_SYMBOLS_D
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                key_level,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                event_kind,
	output logic [mktd_pkg::PATTERN_W-1:0]      symbol_pattern,
	output logic [mktd_pkg::COUNT_W-1:0]        symbol_count,
	input  logic                                cfg_we,
	input  logic [mktd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mktd_pkg::REG_W-1:0]          cfg_wdata
);
	import mktd_pkg::*;

	mktd_cfg_t    cfg;
	mktd_result_t res;

	logic                 valid_s1;
	logic                 key_s1;
	logic                 adv;
	logic                 out_valid_q;
	logic                 event_kind_q;
	logic [PATTERN_W-1:0] pattern_q;
	logic [COUNT_W-1:0]   count_q;

	mktd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mktd_core #(
		.MAX_SYMBOLS_P (MAX_SYMBOLS_P)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.key    (key_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			key_s1 <= key_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.valid;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			event_kind_q <= res.event_kind;
			pattern_q    <= res.symbol_pattern;
			count_q      <= res.symbol_count;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_kind     = event_kind_q;
	assign symbol_pattern = pattern_q;
	assign symbol_count   = count_q;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room to advance");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && key_s1 == $past(key_s1))
		else $error("pending tick lost");

	a_out_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv))
		else $error("result appeared without a tick");

endmodule
